// ===== src/tcw_pkg.sv =====
// tcw_pkg: shared types, codes and helpers of the text console writer.
// No dependencies; used by tcw_radix_unit and text_console_writer.
package tcw_pkg;

    // Command codes carried in the slave tuser
    localparam logic [1:0] CMD_PUT     = 2'd0;
    localparam logic [1:0] CMD_NEWLINE = 2'd1;
    localparam logic [1:0] CMD_NUMBER  = 2'd2;

    // Radix select codes
    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_DEC = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    // Digit buffer geometry: a 32-bit value gives at most 32 digits
    localparam int DIGIT_IDX_W = 5;
    localparam int DIGIT_CNT_W = 6;
    localparam logic [DIGIT_IDX_W-1:0] LAST_SLOT = 5'd31;

    // Divide by ten: q = (v * 0xCCCCCCCD) >> 35, exact for every 32-bit v
    localparam logic [31:0] DEC_RECIP = 32'hCCCC_CCCD;
    localparam int          DEC_SHIFT = 35;

    // Character codes
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_A    = 8'h41;

    // Top-level sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } t_tcw_state;

    // Digit unit states
    typedef enum logic [1:0] {
        CV_IDLE,
        CV_MUL,
        CV_DIGIT
    } t_cv_state;

    // Status from the digit unit to the sequencer
    typedef struct packed {
        logic                   done;
        logic [DIGIT_CNT_W-1:0] count;
    } t_conv_stat;

    // Map a digit value to its ASCII character, uppercase for hex
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {4'b0, d};
        end else begin
            c = CHAR_A + {4'b0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

// ===== src/tcw_radix_unit.sv =====
// tcw_radix_unit: iterative radix conversion, one digit per step, digits
// kept least significant first in a 32-entry buffer. Depends on tcw_pkg.
module tcw_radix_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [31:0]                       i_value,
    input  logic [1:0]                        i_radix,
    input  logic [tcw_pkg::DIGIT_IDX_W-1:0]   i_rd_idx,
    output logic [3:0]                        o_rd_digit,
    output tcw_pkg::t_conv_stat               o_stat
);

    tcw_pkg::t_cv_state r_state, n_state;

    logic [31:0]                     r_val;
    logic [31:0]                     r_quot;
    logic [1:0]                      r_radix;
    logic [tcw_pkg::DIGIT_CNT_W-1:0] r_count;
    logic                            r_done;
    logic [3:0]                      r_digits [32];

    logic [63:0] w_prod;
    logic [31:0] w_q10;
    logic [31:0] w_rem;
    logic [3:0]  w_digit;
    logic [31:0] w_next_val;
    logic        w_is_dec;
    logic        w_last;

    // Shared step datapath: shift for binary and hex, reciprocal for decimal
    always_comb begin
        w_is_dec = (r_radix == tcw_pkg::RADIX_DEC);
        w_prod   = {32'b0, r_val} * {32'b0, tcw_pkg::DEC_RECIP};
        w_q10    = {r_quot[28:0], 3'b0} + {r_quot[30:0], 1'b0};
        w_rem    = r_val - w_q10;
        case (r_radix)
            tcw_pkg::RADIX_BIN: begin
                w_digit    = {3'b0, r_val[0]};
                w_next_val = {1'b0, r_val[31:1]};
            end
            tcw_pkg::RADIX_HEX: begin
                w_digit    = r_val[3:0];
                w_next_val = {4'b0, r_val[31:4]};
            end
            default: begin
                w_digit    = w_rem[3:0];
                w_next_val = r_quot;
            end
        endcase
        w_last = (w_next_val == 32'd0) ||
                 (r_count[tcw_pkg::DIGIT_IDX_W-1:0] == tcw_pkg::LAST_SLOT);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcw_pkg::CV_IDLE: begin
                if (i_start) begin
                    n_state = (i_radix == tcw_pkg::RADIX_DEC) ? tcw_pkg::CV_MUL
                                                              : tcw_pkg::CV_DIGIT;
                end
            end
            tcw_pkg::CV_MUL: begin
                n_state = tcw_pkg::CV_DIGIT;
            end
            tcw_pkg::CV_DIGIT: begin
                if (w_last) begin
                    n_state = tcw_pkg::CV_IDLE;
                end else if (w_is_dec) begin
                    n_state = tcw_pkg::CV_MUL;
                end
            end
            default: begin
                n_state = tcw_pkg::CV_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::CV_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == tcw_pkg::CV_DIGIT) && w_last;
            if (r_state == tcw_pkg::CV_IDLE && i_start) begin
                r_count <= '0;
            end else if (r_state == tcw_pkg::CV_DIGIT) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Working value, quotient and digit buffer
    always_ff @(posedge i_clk) begin
        if (r_state == tcw_pkg::CV_IDLE && i_start) begin
            r_val   <= i_value;
            r_radix <= i_radix;
        end else if (r_state == tcw_pkg::CV_DIGIT) begin
            r_val <= w_next_val;
        end
        if (r_state == tcw_pkg::CV_MUL) begin
            r_quot <= {3'b0, w_prod[63:tcw_pkg::DEC_SHIFT]};
        end
        if (r_state == tcw_pkg::CV_DIGIT) begin
            r_digits[r_count[tcw_pkg::DIGIT_IDX_W-1:0]] <= w_digit;
        end
    end

    assign o_rd_digit   = r_digits[i_rd_idx];
    assign o_stat.done  = r_done;
    assign o_stat.count = r_count;

    // Finish only from a digit step
    a_done_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state) == tcw_pkg::CV_DIGIT)
        else $error("digit unit finished outside a digit step");

    // Decimal steps always go through the multiply phase
    a_dec_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::CV_DIGIT && w_is_dec && !w_last) |=>
            r_state == tcw_pkg::CV_MUL)
        else $error("decimal step skipped the multiply phase");

    // A finished conversion has at least one digit
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_count != '0)
        else $error("conversion finished with no digits");

endmodule

// ===== src/text_console_writer.sv =====
// text_console_writer: cursor-tracking text console cell writer with
// number printing. Depends on tcw_pkg and tcw_radix_unit.
//
// Takes one command beat at a time and emits cell writes (address =
// row*COLUMNS+column, data = attribute:character) on the master stream.
// A put-character or newline command is handled as it is accepted; the block
// is ready again once the output register can take a beat. A print-number
// command runs the digit unit for d steps (d = digit count, 1..32), each a
// digit phase for binary and hex and a reciprocal multiply phase then a
// remainder phase for decimal, then emits the d digits most significant
// first at one beat per cycle when the sink keeps up. Printed digits use
// the default color register, which resets to 7. Newline writes nothing;
// unused command or radix codes are dropped. Addresses are masked to
// 11 bits.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: default color
    input  logic        i_cfg_wen,
    input  logic [7:0]  i_cfg_wdata,
    // Command stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [7:0] char_code, [15:8] color, [47:16] number_value,
    // [49:48] radix_select, [55:50] zero
    input  logic [55:0] i_s_tdata,
    // [1:0] command
    input  logic [1:0]  i_s_tuser,
    // Cell write stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [10:0] write_address, [26:11] write_data, [31:27] zero
    output logic [31:0] o_m_tdata,
    output logic        o_m_tlast
);

    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W  = $clog2(COLUMNS + 1);
    localparam int SUM_W  = ROW_W + CNT_W;
    localparam int PROD_W = (SUM_W > 11) ? SUM_W : 11;

    tcw_pkg::t_tcw_state r_state, n_state;

    logic [COL_W-1:0]                r_col, n_col;
    logic [ROW_W-1:0]                r_row, n_row;
    logic [7:0]                      r_color;
    logic [tcw_pkg::DIGIT_IDX_W-1:0] r_idx;
    logic                            r_out_valid;
    logic [10:0]                     r_out_addr;
    logic [15:0]                     r_out_data;
    logic                            r_out_last;

    logic [1:0]  w_cmd;
    logic [7:0]  w_char;
    logic [7:0]  w_attr;
    logic [31:0] w_num;
    logic [1:0]  w_radix;
    logic        w_radix_ok;
    logic        w_acc;
    logic        w_out_free;
    logic        w_put;
    logic        w_newline;
    logic        w_start;
    logic        w_emit;
    logic        w_load;
    logic [7:0]  w_beat_char;
    logic [7:0]  w_beat_attr;
    logic        w_beat_last;
    logic [PROD_W-1:0] w_addr_full;
    logic [3:0]  w_digit;
    tcw_pkg::t_conv_stat w_stat;

    // Unpack the command beat
    assign w_cmd      = i_s_tuser;
    assign w_char     = i_s_tdata[7:0];
    assign w_attr     = i_s_tdata[15:8];
    assign w_num      = i_s_tdata[47:16];
    assign w_radix    = i_s_tdata[49:48];
    assign w_radix_ok = (w_radix == tcw_pkg::RADIX_BIN) ||
                        (w_radix == tcw_pkg::RADIX_DEC) ||
                        (w_radix == tcw_pkg::RADIX_HEX);

    tcw_radix_unit u_radix (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_value    (w_num),
        .i_radix    (w_radix),
        .i_rd_idx   (r_idx),
        .o_rd_digit (w_digit),
        .o_stat     (w_stat)
    );

    // Handshake and beat selection
    always_comb begin
        w_out_free  = !r_out_valid || i_m_tready;
        o_s_tready  = (r_state == tcw_pkg::ST_IDLE) && w_out_free;
        w_acc       = i_s_tvalid && o_s_tready;
        w_put       = w_acc && (w_cmd == tcw_pkg::CMD_PUT);
        w_newline   = w_acc && (w_cmd == tcw_pkg::CMD_NEWLINE);
        w_start     = w_acc && (w_cmd == tcw_pkg::CMD_NUMBER) && w_radix_ok;
        w_emit      = (r_state == tcw_pkg::ST_EMIT) && w_out_free;
        w_load      = w_put || w_emit;
        w_beat_char = w_emit ? tcw_pkg::digit_char(w_digit) : w_char;
        w_beat_attr = w_emit ? r_color : w_attr;
        w_beat_last = w_emit ? (r_idx == '0) : 1'b1;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcw_pkg::ST_IDLE: begin
                if (w_start) begin
                    n_state = tcw_pkg::ST_CONVERT;
                end
            end
            tcw_pkg::ST_CONVERT: begin
                if (w_stat.done) begin
                    n_state = tcw_pkg::ST_EMIT;
                end
            end
            tcw_pkg::ST_EMIT: begin
                if (w_emit && r_idx == '0) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    // Cell address of the cursor
    assign w_addr_full = PROD_W'(r_row) * PROD_W'(COLUMNS) + PROD_W'(r_col);

    // Advance the cursor after a write, or move it down on newline
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_load) begin
            if (r_col == COL_W'(COLUMNS - 1)) begin
                n_col = '0;
                n_row = (r_row == ROW_W'(ROWS - 1)) ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end else if (w_newline) begin
            n_col = '0;
            n_row = (r_row == ROW_W'(ROWS - 1)) ? '0 : r_row + 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::ST_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_color     <= 8'd7;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            if (i_cfg_wen) begin
                r_color <= i_cfg_wdata;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == tcw_pkg::ST_CONVERT && w_stat.done) begin
                r_idx <= w_stat.count[tcw_pkg::DIGIT_IDX_W-1:0] - 1'b1;
            end else if (w_emit) begin
                r_idx <= r_idx - 1'b1;
            end
        end
    end

    // Output beat payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_addr <= w_addr_full[10:0];
            r_out_data <= {w_beat_attr, w_beat_char};
            r_out_last <= w_beat_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out_data, r_out_addr};
    assign o_m_tlast  = r_out_last;

    // Cursor stays on the screen
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < COLUMNS)
        else $error("cursor column off screen");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < ROWS)
        else $error("cursor row off screen");

    // A valid print command starts a conversion and holds off new commands
    a_start_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == tcw_pkg::ST_CONVERT) && !o_s_tready)
        else $error("print command did not start a conversion");

    // Last digit beat returns the sequencer to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && r_idx == '0) |=> (r_state == tcw_pkg::ST_IDLE) && o_m_tlast)
        else $error("last digit did not end the run");

endmodule

// ===== bench/tcw_checker.sv =====
// tcw_checker: watches the command, cell-write and config ports of the text
// console writer, predicts every cell write and compares it. Uses tcw_pkg.
module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [55:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [10:0] addr;
        logic [15:0] data;
        logic        last;
    } t_cell_write;

    // Cell writes predicted but not yet seen on the master side
    t_cell_write cell_writes_due[$];

    int         col_pos     = 0;
    int         row_pos     = 0;
    logic [7:0] digit_color = 8'd7;
    int         fail_total  = 0;

    // Queue one cell write at the cursor, then advance with line and screen wrap
    task automatic put_cell(input logic [7:0] ch, input logic [7:0] attr, input logic last);
        t_cell_write w;
        int          cell_index;
        cell_index = row_pos * COLUMNS + col_pos;
        w.addr = cell_index[10:0];
        w.data = {attr, ch};
        w.last = last;
        cell_writes_due.push_back(w);
        col_pos++;
        if (col_pos >= COLUMNS) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= ROWS) begin
            col_pos = 0;
            row_pos = 0;
        end
    endtask

    // Convert a value to digits, then queue them most significant first
    task automatic print_number(input logic [31:0] value, input logic [1:0] radix_code);
        logic [31:0] rest;
        logic [31:0] base;
        logic [31:0] d;
        logic [7:0]  digits [0:31];
        int          count;
        base = 32'd2;
        case (radix_code)
            tcw_pkg::RADIX_BIN: base = 32'd2;
            tcw_pkg::RADIX_DEC: base = 32'd10;
            tcw_pkg::RADIX_HEX: base = 32'd16;
            default: return;
        endcase
        count = 0;
        rest  = value;
        do begin
            d    = rest % base;
            rest = rest / base;
            digits[count] = (d < 32'd10) ? (tcw_pkg::CHAR_ZERO + d[7:0])
                                         : (tcw_pkg::CHAR_A + d[7:0] - 8'd10);
            count++;
        end while (rest != 32'd0 && count < 32);
        for (int k = 0; k < count; k++) begin
            put_cell(digits[count-1-k], digit_color, k == count - 1);
        end
    endtask

    // Apply one accepted command beat to the console state
    task automatic console_command(input logic [1:0] cmd, input logic [55:0] payload);
        case (cmd)
            tcw_pkg::CMD_PUT: put_cell(payload[7:0], payload[15:8], 1'b1);
            tcw_pkg::CMD_NEWLINE: begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= ROWS) begin
                    row_pos = 0;
                end
            end
            tcw_pkg::CMD_NUMBER: print_number(payload[47:16], payload[49:48]);
            default: ;
        endcase
    endtask

    // Check output beats first, then predict from input beats, then take config
    always @(posedge i_clk) begin : watch
        t_cell_write want;
        if (!i_rst_n) begin
            col_pos     = 0;
            row_pos     = 0;
            digit_color = 8'd7;
            cell_writes_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (cell_writes_due.size() == 0) begin
                    $error("unexpected cell write: address %0d data %h last %b",
                           i_m_tdata[10:0], i_m_tdata[26:11], i_m_tlast);
                    fail_total++;
                end else begin
                    want = cell_writes_due.pop_front();
                    if (i_m_tdata[10:0] !== want.addr) begin
                        $error("write_address: expected %0d, actual %0d",
                               want.addr, i_m_tdata[10:0]);
                        fail_total++;
                    end
                    if (i_m_tdata[26:11] !== want.data) begin
                        $error("write_data: expected %h, actual %h",
                               want.data, i_m_tdata[26:11]);
                        fail_total++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $error("last_of_run: expected %b, actual %b", want.last, i_m_tlast);
                        fail_total++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                console_command(i_s_tuser, i_s_tdata);
            end
            if (i_cfg_wen) begin
                digit_color = i_cfg_wdata;
            end
        end
        o_fail_count = fail_total;
        o_pending    = cell_writes_due.size();
    end

endmodule

// ===== bench/tb_text_console_writer.sv =====
// tb_text_console_writer: drives commands, backpressure and color writes into
// text_console_writer; tcw_checker predicts and compares. Uses tcw_pkg.
module tb_text_console_writer;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam logic [1:0] RADIX_UNUSED   = 2'd3;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         SQUEEZE_CYCLES = 400;
    localparam int         SETTLE_CYCLES  = 100;
    localparam int         PHASE_ITEMS    = 120;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_wen   = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'd0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [55:0] i_s_tdata   = 56'd0;
    logic [1:0]  i_s_tuser   = 2'd0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [31:0] o_m_tdata;
    logic        o_m_tlast;

    int fail_count;
    int pending_writes;
    int quiet_cycles = 0;
    bit quiet_tail   = 1'b0;
    bit squeeze_req  = 1'b0;
    bit squeeze_done = 1'b0;

    always #6 i_clk = ~i_clk;

    text_console_writer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wen  (i_cfg_wen),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    tcw_checker #(.COLUMNS(80), .ROWS(25)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tlast   (o_m_tlast),
        .o_fail_count(fail_count),
        .o_pending   (pending_writes)
    );

    // Offer one command beat, hold until accepted, then maybe drop valid for a burst
    task automatic send_command(input logic [1:0] cmd, input logic [7:0] ch,
                                input logic [7:0] attr, input logic [31:0] value,
                                input logic [1:0] radix);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {6'd0, radix, value, attr, ch};
        do @(posedge i_clk); while (!o_s_tready);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // Pick a random command, mostly puts and number prints with varied magnitudes
    task automatic send_random_command();
        int          pick;
        logic [1:0]  cmd;
        logic [1:0]  radix;
        logic [31:0] value;
        logic [7:0]  ch;
        logic [7:0]  attr;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            cmd = tcw_pkg::CMD_PUT;
        end else if (pick < 60) begin
            cmd = tcw_pkg::CMD_NEWLINE;
        end else if (pick < 95) begin
            cmd = tcw_pkg::CMD_NUMBER;
        end else begin
            cmd = CMD_UNUSED;
        end
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            radix = RADIX_UNUSED;
        end else if (pick < 7) begin
            radix = tcw_pkg::RADIX_BIN;
        end else if (pick < 14) begin
            radix = tcw_pkg::RADIX_DEC;
        end else begin
            radix = tcw_pkg::RADIX_HEX;
        end
        case ($urandom_range(0, 5))
            0: value = $urandom();
            1: value = $urandom_range(0, 20);
            2: value = $urandom() >> $urandom_range(0, 31);
            3: value = 32'd0;
            4: value = 32'hFFFF_FFFF;
            default: value = $urandom() >> $urandom_range(16, 31);
        endcase
        ch   = 8'($urandom());
        attr = 8'($urandom());
        send_command(cmd, ch, attr, value, radix);
    endtask

    // Drain the block, let any silent work finish, then write the color register
    task automatic set_color(input logic [7:0] color);
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_writes != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= color;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    // Receiver: random ready bursts, one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (squeeze_req && !squeeze_done) begin
                i_m_tready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge i_clk);
                squeeze_done = 1'b1;
                i_m_tready <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles in which neither side moves a beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_text_console_writer: errors");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] color;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, each radix, zero, full width, ignored codes
        send_command(tcw_pkg::CMD_PUT, 8'h00, 8'h00, 32'd0, tcw_pkg::RADIX_BIN);
        send_command(tcw_pkg::CMD_PUT, 8'hFF, 8'hFF, 32'hFFFF_FFFF, RADIX_UNUSED);
        send_command(tcw_pkg::CMD_NEWLINE, 8'hFF, 8'hFF, 32'hFFFF_FFFF, RADIX_UNUSED);
        send_command(tcw_pkg::CMD_NUMBER, 8'h00, 8'h00, 32'd0, tcw_pkg::RADIX_BIN);
        send_command(tcw_pkg::CMD_NUMBER, 8'h00, 8'h00, 32'd0, tcw_pkg::RADIX_DEC);
        send_command(tcw_pkg::CMD_NUMBER, 8'h00, 8'h00, 32'd0, tcw_pkg::RADIX_HEX);
        send_command(tcw_pkg::CMD_NUMBER, 8'h5A, 8'hA5, 32'hFFFF_FFFF, tcw_pkg::RADIX_BIN);
        send_command(tcw_pkg::CMD_NUMBER, 8'h5A, 8'hA5, 32'hFFFF_FFFF, tcw_pkg::RADIX_DEC);
        send_command(tcw_pkg::CMD_NUMBER, 8'h5A, 8'hA5, 32'hFFFF_FFFF, tcw_pkg::RADIX_HEX);
        send_command(tcw_pkg::CMD_NUMBER, 8'h00, 8'h00, 32'h8000_0000, tcw_pkg::RADIX_BIN);
        send_command(tcw_pkg::CMD_NUMBER, 8'h00, 8'h00, 32'd1, tcw_pkg::RADIX_BIN);
        send_command(tcw_pkg::CMD_NUMBER, 8'h00, 8'h00, 32'd9, tcw_pkg::RADIX_DEC);
        send_command(tcw_pkg::CMD_NUMBER, 8'h00, 8'h00, 32'd10, tcw_pkg::RADIX_DEC);
        send_command(tcw_pkg::CMD_NUMBER, 8'h00, 8'h00, 32'hABCD_EF09, tcw_pkg::RADIX_HEX);
        send_command(tcw_pkg::CMD_NUMBER, 8'h00, 8'h00, 32'd15, tcw_pkg::RADIX_HEX);
        send_command(CMD_UNUSED, 8'h41, 8'h1F, 32'd77, tcw_pkg::RADIX_DEC);
        send_command(tcw_pkg::CMD_NUMBER, 8'h41, 8'h1F, 32'd123, RADIX_UNUSED);
        send_command(tcw_pkg::CMD_PUT, 8'h41, 8'h1F, 32'd0, tcw_pkg::RADIX_BIN);
        send_command(tcw_pkg::CMD_NEWLINE, 8'h00, 8'h00, 32'd0, tcw_pkg::RADIX_BIN);
        send_command(tcw_pkg::CMD_NEWLINE, 8'h00, 8'h00, 32'd0, tcw_pkg::RADIX_BIN);
        send_command(tcw_pkg::CMD_PUT, 8'h7E, 8'h70, 32'd0, tcw_pkg::RADIX_BIN);

        // Random phases, each under its own digit color
        set_color(8'h00);
        repeat (PHASE_ITEMS) send_random_command();

        set_color(8'hFF);
        squeeze_req = 1'b1;
        repeat (PHASE_ITEMS) send_random_command();

        color = 8'($urandom());
        set_color(color);
        repeat (PHASE_ITEMS) send_random_command();

        color = 8'($urandom());
        set_color(color);
        repeat (PHASE_ITEMS / 2) send_random_command();
        quiet_tail = 1'b1;
        repeat (PHASE_ITEMS / 2) send_random_command();
        i_s_tvalid <= 1'b0;

        // Drain, then allow the pipeline to settle before the verdict
        @(negedge i_clk);
        while (pending_writes != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending_writes == 0) begin
            $display("tb_text_console_writer: clean");
        end else begin
            $display("tb_text_console_writer: errors");
        end
        $finish;
    end

endmodule
